>>> rtl/sic_pkg.sv
// Shared constants for the segment intersection check.
`default_nettype none
package sic_pkg;
	// Width of the tolerance register.
	localparam int TOL_BITS = 8;
	// Tolerance after reset, in pixels.
	localparam logic [TOL_BITS-1:0] TOL_RESET = 8'd10;
	// Index of a box bound in the bound array carried down the pipeline.
	typedef enum logic [2:0] {
		BND_AXLO = 3'd0,
		BND_AXHI = 3'd1,
		BND_AYLO = 3'd2,
		BND_AYHI = 3'd3,
		BND_BXLO = 3'd4,
		BND_BXHI = 3'd5,
		BND_BYLO = 3'd6,
		BND_BYHI = 3'd7
	} bnd_idx_t;
endpackage
`default_nettype wire

>>> rtl/segment_intersection_check.sv
// Segment intersection check: line crossing point with tolerance box test.
// Throughput is one word per cycle; the whole pipeline advances together and holds on a stall.
// The long part is the restoring divider, one quotient bit per stage for each coordinate.
// Reset clears all valid bits and sets the tolerance register to 10.
`default_nettype none
module segment_intersection_check #(
	parameter int COORD_BITS = 12,
	parameter int FRAC_BITS  = 4
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   cfg_valid,
	output logic                                  cfg_ready,
	input  wire  [sic_pkg::TOL_BITS-1:0]          cfg_data,
	input  wire                                   in_valid,
	output logic                                  in_ready,
	input  wire  [COORD_BITS-1:0]                 first_x1,
	input  wire  [COORD_BITS-1:0]                 first_y1,
	input  wire  [COORD_BITS-1:0]                 first_x2,
	input  wire  [COORD_BITS-1:0]                 first_y2,
	input  wire  [COORD_BITS-1:0]                 second_x1,
	input  wire  [COORD_BITS-1:0]                 second_y1,
	input  wire  [COORD_BITS-1:0]                 second_x2,
	input  wire  [COORD_BITS-1:0]                 second_y2,
	output logic                                  out_valid,
	input  wire                                   out_ready,
	output logic                                  found,
	output logic signed [COORD_BITS+FRAC_BITS+1:0] cross_x,
	output logic signed [COORD_BITS+FRAC_BITS+1:0] cross_y
);
	localparam int C   = COORD_BITS;
	localparam int TB  = sic_pkg::TOL_BITS;
	localparam int BW  = C + FRAC_BITS + 2;     // bounds and result width
	localparam int QB  = C + FRAC_BITS + 1;     // quotient magnitude bits
	localparam int DXW = C + 1;                 // coordinate differences
	localparam int PDW = 2 * C + 2;             // difference products
	localparam int PCW = 2 * C;                 // coordinate products
	localparam int DW  = 2 * C + 3;             // determinant
	localparam int CW  = 2 * C + 1;             // cross terms
	localparam int MW  = 3 * C + 2;             // numerator products
	localparam int NW  = 3 * C + 3;             // numerators
	localparam int WW  = 3 * C + 4 + FRAC_BITS; // divider datapath
	localparam int NS  = QB + 7;                // total stages

	// Configuration register; it accepts a write in every cycle.
	logic [TB-1:0] tol_q;
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= sic_pkg::TOL_RESET;
		end else if (cfg_valid) begin
			tol_q <= cfg_data;
		end
	end

	// Global advance: the pipeline moves unless the output word is stalled.
	logic en;
	logic [NS-1:0] vld_q;
	assign en       = !vld_q[NS-1] || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NS-2:0], in_valid};
		end
	end

	// Box bounds in fixed point, computed at entry.
	logic signed [BW-1:0] bnd_in [8];
	function automatic logic signed [BW-1:0] lo_bound(input logic [C-1:0] a,
			input logic [C-1:0] b, input logic [TB-1:0] t);
		logic signed [BW-1:0] m;
		m = (a < b) ? $signed(BW'(a)) : $signed(BW'(b));
		return (m - $signed(BW'(t))) <<< FRAC_BITS;
	endfunction
	function automatic logic signed [BW-1:0] hi_bound(input logic [C-1:0] a,
			input logic [C-1:0] b, input logic [TB-1:0] t);
		logic signed [BW-1:0] m;
		m = (a > b) ? $signed(BW'(a)) : $signed(BW'(b));
		return (m + $signed(BW'(t))) <<< FRAC_BITS;
	endfunction
	always_comb begin
		bnd_in[sic_pkg::BND_AXLO] = lo_bound(first_x1, first_x2, tol_q);
		bnd_in[sic_pkg::BND_AXHI] = hi_bound(first_x1, first_x2, tol_q);
		bnd_in[sic_pkg::BND_AYLO] = lo_bound(first_y1, first_y2, tol_q);
		bnd_in[sic_pkg::BND_AYHI] = hi_bound(first_y1, first_y2, tol_q);
		bnd_in[sic_pkg::BND_BXLO] = lo_bound(second_x1, second_x2, tol_q);
		bnd_in[sic_pkg::BND_BXHI] = hi_bound(second_x1, second_x2, tol_q);
		bnd_in[sic_pkg::BND_BYLO] = lo_bound(second_y1, second_y2, tol_q);
		bnd_in[sic_pkg::BND_BYHI] = hi_bound(second_y1, second_y2, tol_q);
	end

	// Bounds travel with the word up to the output stage.
	logic signed [BW-1:0] bnd_sn [NS-1][8];
	always_ff @(posedge clk) begin
		if (en) begin
			bnd_sn[0] <= bnd_in;
			for (int k = 1; k < NS - 1; k++) begin
				bnd_sn[k] <= bnd_sn[k-1];
			end
		end
	end

	// Stage 1: register coordinates and form endpoint differences.
	logic [C-1:0] x1_s1, y1_s1, x2_s1, y2_s1, x3_s1, y3_s1, x4_s1, y4_s1;
	logic signed [DXW-1:0] dx12_s1, dy12_s1, dx34_s1, dy34_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			x1_s1   <= first_x1;
			y1_s1   <= first_y1;
			x2_s1   <= first_x2;
			y2_s1   <= first_y2;
			x3_s1   <= second_x1;
			y3_s1   <= second_y1;
			x4_s1   <= second_x2;
			y4_s1   <= second_y2;
			dx12_s1 <= $signed({1'b0, first_x1}) - $signed({1'b0, first_x2});
			dy12_s1 <= $signed({1'b0, first_y1}) - $signed({1'b0, first_y2});
			dx34_s1 <= $signed({1'b0, second_x1}) - $signed({1'b0, second_x2});
			dy34_s1 <= $signed({1'b0, second_y1}) - $signed({1'b0, second_y2});
		end
	end

	// Stage 2: determinant and cross-term products.
	logic signed [PDW-1:0] pd0_s2, pd1_s2;
	logic [PCW-1:0] pc0_s2, pc1_s2, pc2_s2, pc3_s2;
	logic signed [DXW-1:0] dx12_s2, dy12_s2, dx34_s2, dy34_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			pd0_s2  <= PDW'(dx12_s1) * PDW'(dy34_s1);
			pd1_s2  <= PDW'(dy12_s1) * PDW'(dx34_s1);
			pc0_s2  <= PCW'(x1_s1) * PCW'(y2_s1);
			pc1_s2  <= PCW'(y1_s1) * PCW'(x2_s1);
			pc2_s2  <= PCW'(x3_s1) * PCW'(y4_s1);
			pc3_s2  <= PCW'(y3_s1) * PCW'(x4_s1);
			dx12_s2 <= dx12_s1;
			dy12_s2 <= dy12_s1;
			dx34_s2 <= dx34_s1;
			dy34_s2 <= dy34_s1;
		end
	end

	// Stage 3: determinant and the two line constants.
	logic signed [DW-1:0] det_s3;
	logic signed [CW-1:0] c12_s3, c34_s3;
	logic signed [DXW-1:0] dx12_s3, dy12_s3, dx34_s3, dy34_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			det_s3  <= DW'(pd0_s2) - DW'(pd1_s2);
			c12_s3  <= $signed({1'b0, pc0_s2}) - $signed({1'b0, pc1_s2});
			c34_s3  <= $signed({1'b0, pc2_s2}) - $signed({1'b0, pc3_s2});
			dx12_s3 <= dx12_s2;
			dy12_s3 <= dy12_s2;
			dx34_s3 <= dx34_s2;
			dy34_s3 <= dy34_s2;
		end
	end

	// Stage 4: numerator products.
	logic signed [MW-1:0] m0_s4, m1_s4, m2_s4, m3_s4;
	logic signed [DW-1:0] det_s4;
	always_ff @(posedge clk) begin
		if (en) begin
			m0_s4  <= MW'(c12_s3) * MW'(dx34_s3);
			m1_s4  <= MW'(dx12_s3) * MW'(c34_s3);
			m2_s4  <= MW'(c12_s3) * MW'(dy34_s3);
			m3_s4  <= MW'(dy12_s3) * MW'(c34_s3);
			det_s4 <= det_s3;
		end
	end

	// Stage 5: numerators.
	logic signed [NW-1:0] nx_s5, ny_s5;
	logic signed [DW-1:0] det_s5;
	always_ff @(posedge clk) begin
		if (en) begin
			nx_s5  <= NW'(m0_s4) - NW'(m1_s4);
			ny_s5  <= NW'(m2_s4) - NW'(m3_s4);
			det_s5 <= det_s4;
		end
	end

	// Stage 6: magnitudes, quotient signs and range checks for the divider.
	logic [WW-1:0] nmx, nmy, dmag;
	always_comb begin
		nmx  = WW'(nx_s5[NW-1] ? -nx_s5 : nx_s5) << FRAC_BITS;
		nmy  = WW'(ny_s5[NW-1] ? -ny_s5 : ny_s5) << FRAC_BITS;
		dmag = WW'(det_s5[DW-1] ? -det_s5 : det_s5);
	end

	// Divider registers; index 0 is stage 6, index j+1 follows quotient step j.
	logic [WW-1:0] remx_sd [QB+1];
	logic [WW-1:0] remy_sd [QB+1];
	logic [WW-1:0] den_sd  [QB+1];
	logic [QB-1:0] qx_sd   [QB+1];
	logic [QB-1:0] qy_sd   [QB+1];
	logic          sx_sd   [QB+1];
	logic          sy_sd   [QB+1];
	logic          bad_sd  [QB+1];
	logic [WW-1:0] tdiv    [QB];
	logic [QB-1:0] gex, gey;

	// Trial subtraction for each quotient step, most significant bit first.
	always_comb begin
		for (int j = 0; j < QB; j++) begin
			tdiv[j] = den_sd[j] << (QB - 1 - j);
			gex[j]  = remx_sd[j] >= tdiv[j];
			gey[j]  = remy_sd[j] >= tdiv[j];
		end
	end

	// Restoring division, one quotient bit per stage.
	always_ff @(posedge clk) begin
		if (en) begin
			remx_sd[0] <= nmx;
			remy_sd[0] <= nmy;
			den_sd[0]  <= dmag;
			qx_sd[0]   <= '0;
			qy_sd[0]   <= '0;
			sx_sd[0]   <= nx_s5[NW-1] ^ det_s5[DW-1];
			sy_sd[0]   <= ny_s5[NW-1] ^ det_s5[DW-1];
			// Parallel lines, or a quotient too large for any box.
			bad_sd[0]  <= (det_s5 == '0) || (nmx >= (dmag << QB)) || (nmy >= (dmag << QB));
			for (int j = 0; j < QB; j++) begin
				remx_sd[j+1] <= gex[j] ? remx_sd[j] - tdiv[j] : remx_sd[j];
				remy_sd[j+1] <= gey[j] ? remy_sd[j] - tdiv[j] : remy_sd[j];
				qx_sd[j+1]   <= qx_sd[j] | (QB'(gex[j]) << (QB - 1 - j));
				qy_sd[j+1]   <= qy_sd[j] | (QB'(gey[j]) << (QB - 1 - j));
				den_sd[j+1]  <= den_sd[j];
				sx_sd[j+1]   <= sx_sd[j];
				sy_sd[j+1]   <= sy_sd[j];
				bad_sd[j+1]  <= bad_sd[j];
			end
		end
	end

	// Output stage: apply signs and test both boxes.
	logic signed [BW-1:0] px, py;
	logic                 hit;
	logic signed [BW-1:0] bf [8];
	always_comb begin
		bf  = bnd_sn[NS-2];
		px  = sx_sd[QB] ? -$signed(BW'(qx_sd[QB])) : $signed(BW'(qx_sd[QB]));
		py  = sy_sd[QB] ? -$signed(BW'(qy_sd[QB])) : $signed(BW'(qy_sd[QB]));
		hit = !bad_sd[QB]
			&& px >= bf[sic_pkg::BND_AXLO] && px <= bf[sic_pkg::BND_AXHI]
			&& py >= bf[sic_pkg::BND_AYLO] && py <= bf[sic_pkg::BND_AYHI]
			&& px >= bf[sic_pkg::BND_BXLO] && px <= bf[sic_pkg::BND_BXHI]
			&& py >= bf[sic_pkg::BND_BYLO] && py <= bf[sic_pkg::BND_BYHI];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			found   <= hit;
			cross_x <= hit ? px : '0;
			cross_y <= hit ? py : '0;
		end
	end

	assign out_valid = vld_q[NS-1];
endmodule
`default_nettype wire
